@@ hw/rtl/double_ended_queue_top_macros.svh @@
// Assertion macros used by the double-ended queue top module.
`ifndef DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define DEQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define DEQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define DEQ_ASSERT_IMP(label, ante, cons)
`define DEQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ hw/rtl/deq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue package
// Sizes, command and error codes, and the structures passed between modules.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int QUEUE_DEPTH = 1024;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;
  localparam int WORD_W      = 32;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_READ_FRONT = 3'd4,
    CMD_READ_BACK  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [PTR_W-1:0]  addr;
    logic [WORD_W-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic             word_valid;
    logic [CNT_W-1:0] count;
    logic             empty;
    err_t             err;
  } stat_t;

  function automatic logic [PTR_W-1:0] wrap_pos(input logic [SUM_W-1:0] p);
    logic [SUM_W-1:0] r;
    begin
      r = p;
      if (p >= SUM_W'(QUEUE_DEPTH)) begin
        r = p - SUM_W'(QUEUE_DEPTH);
      end
      return r[PTR_W-1:0];
    end
  endfunction

endpackage

@@ hw/rtl/deq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/deq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue pointer control
// Holds the front pointer and the count, decodes each command and issues the
// ring memory access.
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [2:0]                   command,
  input  logic [deq_pkg::WORD_W-1:0]   push_value,
  output deq_pkg::ram_req_t            ram_req,
  output deq_pkg::stat_t               stat
);

  import deq_pkg::*;

  logic [PTR_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] front_dec, front_inc, tail_slot, back_slot;
  logic             full, empty;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign front_dec = (front_r == '0) ? PTR_W'(QUEUE_DEPTH - 1) : front_r - 1'b1;
  assign front_inc = (front_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign tail_slot = wrap_pos(SUM_W'(front_r) + SUM_W'(count_r));
  assign back_slot = (tail_slot == '0) ? PTR_W'(QUEUE_DEPTH - 1) : tail_slot - 1'b1;

  always_comb begin
    front_nxt       = front_r;
    count_nxt       = count_r;
    ram_req.we      = 1'b0;
    ram_req.re      = 1'b0;
    ram_req.addr    = front_r;
    ram_req.wdata   = push_value;
    stat.word_valid = 1'b0;
    stat.err        = ERR_NONE;
    case (cmd_t'(command))
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (full) begin
          stat.err = ERR_FULL;
        end else begin
          ram_req.we = 1'b1;
          count_nxt  = count_r + 1'b1;
          if (cmd_t'(command) == CMD_PUSH_FRONT) begin
            front_nxt    = front_dec;
            ram_req.addr = front_dec;
          end else begin
            ram_req.addr = tail_slot;
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK, CMD_READ_FRONT, CMD_READ_BACK: begin
        if (empty) begin
          stat.err = ERR_EMPTY;
        end else begin
          ram_req.re      = 1'b1;
          stat.word_valid = 1'b1;
          if (cmd_t'(command) == CMD_POP_FRONT || cmd_t'(command) == CMD_READ_FRONT) begin
            ram_req.addr = front_r;
          end else begin
            ram_req.addr = back_slot;
          end
          if (cmd_t'(command) == CMD_POP_FRONT) begin
            front_nxt = front_inc;
            count_nxt = count_r - 1'b1;
          end else if (cmd_t'(command) == CMD_POP_BACK) begin
            count_nxt = count_r - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    ram_req.we = ram_req.we & accept;
    ram_req.re = ram_req.re & accept;
    stat.count = count_nxt;
    stat.empty = (count_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (accept) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

@@ hw/rtl/double_ended_queue_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue
// Ring-buffer deque of signed 32-bit words with one status result per command.
// ----------------------------------------------------------------------------
// The block takes one command per clock cycle while results are being taken,
// and every command returns exactly one result after its transfer: the ring
// memory access, whose single read or write per command sets that rate,
// and the status are registered in the first stage, and the result in the
// output register. A stall on the result side holds the pipeline and stalls
// the input once both stages are full. Words popped or read come from the
// ring memory; pushes on a full queue and pops or reads on an empty queue
// leave the state unchanged and are reported by the error code.

`include "double_ended_queue_top_macros.svh"

module double_ended_queue_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          in_command,
  input  logic signed [deq_pkg::WORD_W-1:0]   in_push_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [deq_pkg::WORD_W-1:0]   out_value,
  output logic                                out_value_valid,
  output logic [deq_pkg::CNT_W-1:0]           out_item_count,
  output logic                                out_is_empty,
  output logic [1:0]                          out_error_code
);

  import deq_pkg::*;

  ram_req_t          ram_req;
  stat_t             stat;
  logic [WORD_W-1:0] rd_data;
  logic              accept, s1_move;
  logic              s1_valid_r;
  stat_t             s1_stat_r;
  logic              out_valid_r;
  stat_t             out_stat_r;
  logic [WORD_W-1:0] out_value_r;

  assign s1_move  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_move;
  assign accept   = in_valid && !in_stall;

  deq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .command    (in_command),
    .push_value (in_push_value),
    .ram_req    (ram_req),
    .stat       (stat)
  );

  deq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.addr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_stat_r <= stat;
    end
    if (s1_move && s1_valid_r) begin
      out_stat_r  <= s1_stat_r;
      out_value_r <= s1_stat_r.word_valid ? rd_data : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_value_valid = out_stat_r.word_valid;
  assign out_item_count  = out_stat_r.count;
  assign out_is_empty    = out_stat_r.empty;
  assign out_error_code  = out_stat_r.err;

  `DEQ_ASSERT_IMP(a_full_count, out_valid && out_error_code == ERR_FULL,
                  out_item_count == CNT_W'(QUEUE_DEPTH) && !out_value_valid)
  `DEQ_ASSERT_IMP(a_empty_status, out_valid && out_error_code == ERR_EMPTY,
                  out_is_empty && out_item_count == '0 && out_value == '0)
  `DEQ_ASSERT_IMP(a_word_ok, out_valid && out_value_valid,
                  out_error_code == ERR_NONE)
  `DEQ_ASSERT_NEXT(a_stall_holds_stage, s1_valid_r && !s1_move,
                   s1_valid_r && $stable(s1_stat_r))

endmodule

@@ sim/deque_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue result checker
// Watches both channels of the double-ended queue, keeps its own ring of
// words, front slot and occupancy, works out the status for every command
// transfer and compares each result transfer, field by field, with the oldest
// status still awaited.
// ----------------------------------------------------------------------------
module deque_result_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [2:0]                        in_command,
  input  logic signed [deq_pkg::WORD_W-1:0] in_push_value,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [deq_pkg::WORD_W-1:0] out_value,
  input  logic                              out_value_valid,
  input  logic [deq_pkg::CNT_W-1:0]         out_item_count,
  input  logic                              out_is_empty,
  input  logic [1:0]                        out_error_code,
  output int                                fail_count,
  output int                                awaited_count,
  output int                                checked_count,
  output int                                full_refusals,
  output int                                empty_refusals,
  output int                                peak_occupancy
);

  import deq_pkg::*;

  typedef struct {
    logic signed [WORD_W-1:0] value;
    logic                     value_valid;
    logic [CNT_W-1:0]         count;
    logic                     empty;
    err_t                     err;
  } deque_status_t;

  logic [WORD_W-1:0] ring_words [QUEUE_DEPTH];
  logic [PTR_W-1:0]  front_slot;
  logic [CNT_W-1:0]  occupancy;
  deque_status_t     awaited_status [$];

  initial begin
    fail_count     = 0;
    awaited_count  = 0;
    checked_count  = 0;
    full_refusals  = 0;
    empty_refusals = 0;
    peak_occupancy = 0;
    front_slot     = '0;
    occupancy      = '0;
  end

  function automatic deque_status_t apply_command(input logic [2:0] cmd,
                                                  input logic [WORD_W-1:0] word);
    deque_status_t st;
    int            slot;
    st.value       = '0;
    st.value_valid = 1'b0;
    st.err         = ERR_NONE;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (int'(occupancy) >= QUEUE_DEPTH) begin
          st.err = ERR_FULL;
        end else if (cmd == CMD_PUSH_FRONT) begin
          front_slot = PTR_W'((int'(front_slot) + QUEUE_DEPTH - 1) % QUEUE_DEPTH);
          ring_words[front_slot] = word;
          occupancy = occupancy + 1'b1;
        end else begin
          ring_words[(int'(front_slot) + int'(occupancy)) % QUEUE_DEPTH] = word;
          occupancy = occupancy + 1'b1;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK, CMD_READ_FRONT, CMD_READ_BACK: begin
        if (occupancy == '0) begin
          st.err = ERR_EMPTY;
        end else begin
          if (cmd == CMD_POP_FRONT || cmd == CMD_READ_FRONT) begin
            slot = int'(front_slot);
          end else begin
            slot = (int'(front_slot) + int'(occupancy) - 1) % QUEUE_DEPTH;
          end
          st.value       = ring_words[slot];
          st.value_valid = 1'b1;
          if (cmd == CMD_POP_FRONT) begin
            front_slot = PTR_W'((int'(front_slot) + 1) % QUEUE_DEPTH);
            occupancy  = occupancy - 1'b1;
          end else if (cmd == CMD_POP_BACK) begin
            occupancy = occupancy - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    st.count = occupancy;
    st.empty = (occupancy == '0);
    return st;
  endfunction

  always @(posedge clk) begin
    deque_status_t want;
    if (!rst_n) begin
      front_slot = '0;
      occupancy  = '0;
      awaited_status.delete();
    end else begin
      // Results are matched first: a result can never belong to a command
      // transferred at the same edge.
      if (out_valid && !out_stall) begin
        if (awaited_status.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("[%0t] unexpected result: value %0d valid %0b count %0d empty %0b err %0d",
                     $realtime, out_value, out_value_valid, out_item_count, out_is_empty,
                     out_error_code);
          end
        end else begin
          want = awaited_status[0];
          awaited_status.delete(0);
          checked_count++;
          if (out_value !== want.value || out_value_valid !== want.value_valid ||
              out_item_count !== want.count || out_is_empty !== want.empty ||
              out_error_code !== want.err) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("[%0t] result %0d expected: value %0d valid %0b count %0d err %0d",
                       $realtime, checked_count, want.value, want.value_valid, want.count,
                       want.err);
              $display("[%0t] result %0d expected: empty %0b",
                       $realtime, checked_count, want.empty);
              $display("[%0t] result %0d actual:   value %0d valid %0b count %0d err %0d",
                       $realtime, checked_count, out_value, out_value_valid, out_item_count,
                       out_error_code);
              $display("[%0t] result %0d actual:   empty %0b",
                       $realtime, checked_count, out_is_empty);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = apply_command(in_command, in_push_value);
        if (want.err == ERR_FULL) full_refusals++;
        if (want.err == ERR_EMPTY) empty_refusals++;
        if (int'(occupancy) > peak_occupancy) peak_occupancy = int'(occupancy);
        awaited_status.insert(awaited_status.size(), want);
      end
    end
    awaited_count = awaited_status.size();
  end

endmodule

@@ sim/double_ended_queue_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives commands into the double-ended queue in random bursts while the
// result side stalls on its own changing pattern. A directed opening covers
// empty-queue pops and reads, unused codes, pointer wrap and extreme words;
// the random part fills the queue to full, works near the top and drains it
// until empty or out of commands; the result checker beside it does the checks.
// ----------------------------------------------------------------------------
module double_ended_queue_top_tb;
  import deq_pkg::*;

  localparam int          TOTAL_COMMANDS = 1950;
  localparam logic [2:0]  CMD_SPARE_LO   = 3'd6;
  localparam logic [2:0]  CMD_SPARE_HI   = 3'd7;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [2:0]               in_command;
  logic signed [WORD_W-1:0] in_push_value;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [WORD_W-1:0] out_value;
  logic                     out_value_valid;
  logic [CNT_W-1:0]         out_item_count;
  logic                     out_is_empty;
  logic [1:0]               out_error_code;

  int fail_count;
  int awaited_count;
  int checked_count;
  int full_refusals;
  int empty_refusals;
  int peak_occupancy;

  int sent_total  = 0;
  int sent_pushes = 0;
  int sent_pops   = 0;
  int sent_reads  = 0;
  int sent_spare  = 0;
  int fill_level  = 0;
  int burst_left  = 0;
  int stall_left  = 0;
  int stall_mode  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  double_ended_queue_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_value       (out_value),
    .out_value_valid (out_value_valid),
    .out_item_count  (out_item_count),
    .out_is_empty    (out_is_empty),
    .out_error_code  (out_error_code)
  );

  deque_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_value       (out_value),
    .out_value_valid (out_value_valid),
    .out_item_count  (out_item_count),
    .out_is_empty    (out_is_empty),
    .out_error_code  (out_error_code),
    .fail_count      (fail_count),
    .awaited_count   (awaited_count),
    .checked_count   (checked_count),
    .full_refusals   (full_refusals),
    .empty_refusals  (empty_refusals),
    .peak_occupancy  (peak_occupancy)
  );

  // The result side switches between free-running, light, heavy and
  // alternating stall patterns for stretches of random length.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 120);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= ~out_stall;
    endcase
  end

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 11))
      0: return {1'b1, {(WORD_W-1){1'b0}}};
      1: return {1'b0, {(WORD_W-1){1'b1}}};
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_command(input int push_pct, input int pop_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    if (roll < push_pct + pop_pct) return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
    if (roll < 97) return $urandom_range(0, 1) ? CMD_READ_BACK : CMD_READ_FRONT;
    return $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
  endfunction

  // Presents one command and holds it until its transfer, then either keeps
  // the burst going or drops valid for a random gap.
  task automatic send_command(input logic [2:0] cmd, input logic [WORD_W-1:0] word);
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_push_value <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_total++;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        sent_pushes++;
        if (fill_level < QUEUE_DEPTH) fill_level++;
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        sent_pops++;
        if (fill_level > 0) fill_level--;
      end
      CMD_READ_FRONT, CMD_READ_BACK: sent_reads++;
      default: sent_spare++;
    endcase
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, ($urandom_range(0, 4) == 0) ? 64 : 8);
    end
  endtask

  initial begin : stimulus
    int drain_cycles;
    int extra;
    in_valid      <= 1'b0;
    in_command    <= CMD_READ_FRONT;
    in_push_value <= '0;
    rst_n         <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: empty queue, unused codes, front pointer wrap,
    // extreme words at both ends, and emptying again.
    send_command(CMD_POP_FRONT, '1);
    send_command(CMD_POP_BACK, pick_word());
    send_command(CMD_READ_FRONT, pick_word());
    send_command(CMD_READ_BACK, pick_word());
    send_command(CMD_SPARE_LO, pick_word());
    send_command(CMD_SPARE_HI, '1);
    send_command(CMD_PUSH_FRONT, 32'h7fff_ffff);
    send_command(CMD_PUSH_BACK, 32'h8000_0000);
    send_command(CMD_PUSH_FRONT, 32'hffff_ffff);
    send_command(CMD_PUSH_BACK, 32'h0000_0000);
    send_command(CMD_READ_FRONT, pick_word());
    send_command(CMD_READ_BACK, pick_word());
    send_command(CMD_POP_BACK, pick_word());
    send_command(CMD_POP_FRONT, pick_word());
    send_command(CMD_SPARE_HI, pick_word());
    send_command(CMD_READ_FRONT, pick_word());
    send_command(CMD_READ_BACK, pick_word());
    send_command(CMD_PUSH_BACK, 32'haaaa_aaaa);
    send_command(CMD_PUSH_FRONT, 32'h5555_5555);
    send_command(CMD_POP_FRONT, pick_word());
    send_command(CMD_POP_FRONT, pick_word());
    send_command(CMD_POP_BACK, pick_word());
    send_command(CMD_POP_BACK, pick_word());
    send_command(CMD_POP_FRONT, pick_word());

    // Balanced traffic at low occupancy, then fill until full and push on.
    repeat (200) send_command(pick_command(40, 40), pick_word());
    while (fill_level < QUEUE_DEPTH) send_command(pick_command(90, 4), pick_word());
    repeat (12) send_command(pick_command(70, 10), pick_word());
    repeat (100) send_command(pick_command(45, 35), pick_word());
    while (fill_level > 0 && sent_total < TOTAL_COMMANDS) begin
      send_command(pick_command(4, 90), pick_word());
    end
    extra = TOTAL_COMMANDS - sent_total;
    repeat (extra) send_command(pick_command(40, 40), pick_word());
    in_valid <= 1'b0;

    drain_cycles = 0;
    while (awaited_count != 0 && drain_cycles < 5000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (10) @(posedge clk);

    $display("Covered %0d commands: %0d pushes, %0d pops, %0d reads, %0d unused codes.",
             sent_total, sent_pushes, sent_pops, sent_reads, sent_spare);
    $display("Checked %0d results; %0d pushes refused when full, %0d empty refusals, peak %0d.",
             checked_count, full_refusals, empty_refusals, peak_occupancy);
    if (awaited_count != 0) begin
      $display("%0d results never arrived.", awaited_count);
    end
    if (fail_count == 0 && awaited_count == 0) begin
      $display("double_ended_queue_top regression: pass");
    end else begin
      $display("double_ended_queue_top regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Run stopped by the time limit.");
    $display("double_ended_queue_top regression: fail");
    $finish;
  end

endmodule
